FILE: rtl/core/mrs_pkg.sv
// Shared types and constants for the monotone row-optimum search block.
// Holds the controller state encoding, the command and status bundles and the
// register map. No dependencies.
`default_nettype none

package mrs_pkg;

  // Register map of the configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int DIM_W      = 7;
  localparam int MODE_W     = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd2;

  localparam logic [DIM_W-1:0]  ROWS_RESET = 7'd64;
  localparam logic [DIM_W-1:0]  COLS_RESET = 7'd64;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;

  // Bit positions inside the mode register.
  localparam int MODE_LEFTMOST_BIT = 0;
  localparam int MODE_MINIMUM_BIT  = 1;

  // Widths of the result fields.
  localparam int ROW_OUT_W = 6;
  localparam int COL_OUT_W = 6;

  // Controller states.
  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_POP,
    S_BASE,
    S_SCAN,
    S_DRAIN,
    S_PUSH,
    S_EMIT_RD,
    S_EMIT_OUT
  } mrs_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_en;
    logic stack_init;
    logic span_pop;
    logic base_calc;
    logic scan_issue;
    logic span_push;
    logic emit_read;
    logic emit_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_cell;
    logic last_col;
    logic search_done;
    logic out_free;
    logic last_emit;
  } ctrl_sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/mrs_ctrl.sv
// Sequencing state machine of the monotone row-optimum search.
// Drives the datapath through load, search and result phases.
// Depends on mrs_pkg.
`default_nettype none

module mrs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cell_valid,
  input  mrs_pkg::ctrl_sts_t sts,
  output mrs_pkg::ctrl_cmd_t cmd,
  output logic              cell_ready
);
  import mrs_pkg::*;

  mrs_state_t state;
  mrs_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cell_ready = 1'b0;
    unique case (state)
      S_LOAD: begin
        cell_ready  = 1'b1;
        cmd.load_en = cell_valid;
        if (cell_valid && sts.last_cell) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.stack_init = 1'b1;
        state_next     = S_POP;
      end
      S_POP: begin
        cmd.span_pop = 1'b1;
        state_next   = S_BASE;
      end
      S_BASE: begin
        cmd.base_calc = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.last_col) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The last column read is compared in this cycle.
        state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.span_push = 1'b1;
        state_next    = sts.search_done ? S_EMIT_RD : S_POP;
      end
      S_EMIT_RD: begin
        cmd.emit_read = 1'b1;
        state_next    = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          state_next    = sts.last_emit ? S_LOAD : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // The search ends only once the range stack has run dry.
  a_done_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && sts.search_done) |=> (state == S_EMIT_RD))
    else $error("search finished but emission did not start");

  // The element that completes the matrix starts the search.
  a_trigger: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_en && sts.last_cell) |=> (state == S_INIT))
    else $error("final element did not start the search");

  // After the final row is handed over the block takes elements again.
  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_load && sts.last_emit) |=> cell_ready)
    else $error("block not ready for a new matrix after last row");

endmodule

`default_nettype wire

FILE: rtl/core/mrs_dpath.sv
// Datapath of the monotone row-optimum search: matrix store, range stack,
// column scanner, best-column store and result register.
// Depends on mrs_pkg; sequenced by mrs_ctrl.
`default_nettype none

module mrs_dpath #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 32,
  parameter int RW         = $clog2(MAX_ROWS + 1),
  parameter int WW         = $clog2(MAX_COLS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mrs_pkg::ctrl_cmd_t            cmd,
  output mrs_pkg::ctrl_sts_t            sts,
  input  logic [RW-1:0]                 h_eff,
  input  logic [WW-1:0]                 w_eff,
  input  logic [1:0]                    mode,
  input  logic signed [VALUE_BITS-1:0]  cell_value,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [mrs_pkg::ROW_OUT_W-1:0] row_index,
  output logic [mrs_pkg::COL_OUT_W-1:0] best_column,
  output logic                          last_row
);
  import mrs_pkg::*;

  localparam int XW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int SD    = XW + 2;
  localparam int SIW   = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);

  typedef struct packed {
    logic [RW-1:0] lo;
    logic [RW-1:0] hi;
    logic [CW-1:0] lb;
    logic [CW-1:0] ub;
  } span_t;

  // Storage.
  logic signed [VALUE_BITS-1:0] matrix_mem [DEPTH];
  logic [CW-1:0]                bcs_mem [MAX_ROWS];
  span_t                        stack_mem [SD];

  // Load side.
  logic [LW-1:0]      load_count;
  logic [RW+WW-1:0]   total;

  // Search side.
  logic [SPW-1:0]               sp;
  span_t                        cur;
  logic [XW-1:0]                mid;
  logic [AW-1:0]                row_base;
  logic [CW-1:0]                col;
  logic [AW-1:0]                rd_addr;
  logic signed [VALUE_BITS-1:0] rd_data;
  logic                         rd_pend;
  logic [CW-1:0]                rd_col;
  logic                         scan_first;
  logic signed [VALUE_BITS-1:0] best_val;
  logic [CW-1:0]                arg;
  logic                         better;
  span_t                        top_span;
  logic [RW:0]                  top_sum;
  logic [XW+WW-1:0]             base_prod;
  logic                         push_hi;
  logic                         push_lo;
  span_t                        hi_span;
  span_t                        lo_span;
  logic [SIW-1:0]               idx_hi;
  logic [SIW-1:0]               idx_lo;

  // Emission side.
  logic [XW-1:0] emit_row;
  logic [CW-1:0] bcs_rd;

  // Element count and end-of-matrix detection.
  assign total = {{WW{1'b0}}, h_eff} * {{RW{1'b0}}, w_eff};
  assign sts.last_cell = (32'(load_count) + 32'd1) >= 32'(total);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (cmd.load_en) begin
      load_count <= sts.last_cell ? '0 : load_count + 1'b1;
    end
  end

  // Matrix store: written in arrival order, read one column per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      matrix_mem[load_count[AW-1:0]] <= cell_value;
    end
  end

  assign rd_addr = row_base + AW'(col);

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      rd_data <= matrix_mem[rd_addr];
    end
  end

  // Top of the range stack and its middle row.
  assign top_span = stack_mem[SIW'(sp - 1'b1)];
  assign top_sum  = {1'b0, top_span.lo} + {1'b0, top_span.hi};
  assign base_prod = {{WW{1'b0}}, mid} * {{XW{1'b0}}, w_eff};

  // Child ranges; empty ones are never pushed.
  assign push_hi = ((RW + 1)'(mid) + 1'b1) < {1'b0, cur.hi};
  assign push_lo = cur.lo < RW'(mid);

  always_comb begin
    hi_span    = cur;
    hi_span.lo = RW'(mid) + 1'b1;
    hi_span.lb = arg;
    lo_span    = cur;
    lo_span.hi = RW'(mid);
    lo_span.ub = arg;
  end

  assign idx_hi = SIW'(sp);
  assign idx_lo = SIW'(sp + SPW'(push_hi));

  assign sts.search_done = (sp == '0) && !push_hi && !push_lo;
  assign sts.last_col    = (col == cur.ub);

  // Range stack and span registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.stack_init) begin
      sp <= SPW'(1);
    end else if (cmd.span_pop) begin
      sp <= sp - 1'b1;
    end else if (cmd.span_push) begin
      sp <= sp + SPW'(push_hi) + SPW'(push_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stack_init) begin
      stack_mem[0] <= '{lo: '0, hi: h_eff, lb: '0, ub: CW'(w_eff - 1'b1)};
    end else if (cmd.span_push) begin
      if (push_hi) begin
        stack_mem[idx_hi] <= hi_span;
      end
      if (push_lo) begin
        stack_mem[idx_lo] <= lo_span;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.span_pop) begin
      cur <= top_span;
      mid <= XW'(top_sum >> 1);
    end
    if (cmd.base_calc) begin
      row_base <= AW'(base_prod);
      col      <= cur.lb;
    end else if (cmd.scan_issue) begin
      col <= col + 1'b1;
    end
  end

  // Comparison under the selected mode.
  always_comb begin
    if (mode[MODE_MINIMUM_BIT]) begin
      better = mode[MODE_LEFTMOST_BIT] ? (rd_data < best_val) : (rd_data <= best_val);
    end else begin
      better = mode[MODE_LEFTMOST_BIT] ? (rd_data > best_val) : (rd_data >= best_val);
    end
  end

  // Running optimum of the current row window.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      rd_col <= col;
    end
    if (cmd.base_calc) begin
      scan_first <= 1'b1;
    end else if (rd_pend) begin
      scan_first <= 1'b0;
      if (scan_first || better) begin
        best_val <= rd_data;
        arg      <= rd_col;
      end
    end
  end

  // Best-column store: written once per searched row, read in row order.
  always_ff @(posedge clk) begin
    if (cmd.span_push) begin
      bcs_mem[mid] <= arg;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_read) begin
      bcs_rd <= bcs_mem[emit_row];
    end
  end

  // Row counter of the result phase.
  assign sts.last_emit = (RW'(emit_row) + 1'b1) == h_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_row <= '0;
    end else if (cmd.stack_init) begin
      emit_row <= '0;
    end else if (cmd.emit_load) begin
      emit_row <= emit_row + 1'b1;
    end
  end

  // Result register.
  assign sts.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      row_index   <= ROW_OUT_W'(emit_row);
      best_column <= COL_OUT_W'(bcs_rd);
      last_row    <= sts.last_emit;
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(SD))
    else $error("range stack overflow");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.span_pop |-> (sp != '0))
    else $error("pop from an empty range stack");

  a_scan_window: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_issue |-> (col >= cur.lb && col <= cur.ub))
    else $error("column read outside the current window");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_load |-> (!res_valid || res_ready))
    else $error("result register overwritten before it was taken");

endmodule

`default_nettype wire

FILE: rtl/core/monotone_row_argmax_search.sv
// Monotone row-optimum search.
//
// Three channels, each with valid and ready. The configuration channel
// (cfg_index, cfg_data) sets rows, columns and search mode; it is always
// ready and must only be used while the block is idle. The cell channel
// takes one signed matrix element per transaction in row-major order, at one
// element per cycle while a matrix is being loaded. The transaction that
// completes the matrix starts the search; no element is taken until every
// result has been handed over.
// The search visits each row range once: for every range it pops the range,
// computes the row base address, then scans the columns of its window, one
// read per cycle from the single-port matrix store, compares the last read
// and pushes the child ranges. Results then leave in ascending row order;
// each row is read from the best-column store before it is loaded into the
// result register, and last_row marks the final row.
// A stalled result channel simply holds the current result and pauses the
// search output; nothing is lost. Reset returns to the loading phase with an
// empty element count and the registers at 64 rows, 64 columns, maximum with
// rightmost ties; the stores are left as they were.
`default_nettype none

module monotone_row_argmax_search #(
  parameter int MAX_ROWS   = 64,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mrs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           cell_valid,
  output logic                           cell_ready,
  input  logic signed [VALUE_BITS-1:0]   cell_value,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [mrs_pkg::ROW_OUT_W-1:0]  row_index,
  output logic [mrs_pkg::COL_OUT_W-1:0]  best_column,
  output logic                           last_row
);
  import mrs_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int WW = $clog2(MAX_COLS + 1);

  logic [DIM_W-1:0]  rows_cfg;
  logic [DIM_W-1:0]  cols_cfg;
  logic [MODE_W-1:0] mode_cfg;
  logic [RW-1:0]     h_eff;
  logic [WW-1:0]     w_eff;
  ctrl_cmd_t         cmd;
  ctrl_sts_t         sts;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= ROWS_RESET;
      cols_cfg <= COLS_RESET;
      mode_cfg <= MODE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROWS: rows_cfg <= cfg_data[DIM_W-1:0];
        CFG_COLS: cols_cfg <= cfg_data[DIM_W-1:0];
        CFG_MODE: mode_cfg <= cfg_data[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Dimensions in use: zero acts as one, oversize saturates.
  always_comb begin
    if (rows_cfg == '0) begin
      h_eff = RW'(1);
    end else if (int'(rows_cfg) > MAX_ROWS) begin
      h_eff = RW'(MAX_ROWS);
    end else begin
      h_eff = RW'(rows_cfg);
    end
    if (cols_cfg == '0) begin
      w_eff = WW'(1);
    end else if (int'(cols_cfg) > MAX_COLS) begin
      w_eff = WW'(MAX_COLS);
    end else begin
      w_eff = WW'(cols_cfg);
    end
  end

  mrs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cell_valid (cell_valid),
    .sts        (sts),
    .cmd        (cmd),
    .cell_ready (cell_ready)
  );

  mrs_dpath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS),
    .RW         (RW),
    .WW         (WW)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .h_eff       (h_eff),
    .w_eff       (w_eff),
    .mode        (mode_cfg),
    .cell_value  (cell_value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .row_index   (row_index),
    .best_column (best_column),
    .last_row    (last_row)
  );

endmodule

`default_nettype wire
